// ----- rtl/sgr_pkg.sv -----
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants of the ANSI SGR color parser
// Beat structs, parser mode and event codes, character codes and the
// fixed SGR color palette with its lookup function.
// ----------------------------------------------------------------------------
package sgr_pkg;

	// Parser mode
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} sgr_mode_t;

	// Output event codes
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_GLYPH   = 2'd1,
		EV_NEWLINE = 2'd2,
		EV_CR      = 2'd3
	} sgr_event_t;

	// Input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       string_end;
	} sgr_in_t;

	// Output beat
	typedef struct packed {
		sgr_event_t  event_kind;
		logic [7:0]  glyph;
		logic [31:0] glyph_color;
		logic        end_flag;
	} sgr_out_t;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	localparam int          CODE_W      = 7;
	localparam logic [6:0]  CODE_MAX    = 7'd127;
	localparam logic [31:0] DEFAULT_RST = 32'hFFFF_FFFF;

	// SGR code ranges
	localparam logic [6:0] FG_LO   = 7'd30;
	localparam logic [6:0] FG_HI   = 7'd37;
	localparam logic [6:0] FG_B_LO = 7'd90;
	localparam logic [6:0] FG_B_HI = 7'd97;

	localparam logic [31:0] PALETTE [8] = '{
		32'hFF50_5050, 32'hFFE0_2020, 32'hFF30_B030, 32'hFFF2_C200,
		32'hFF48_78E0, 32'hFFC0_40C0, 32'hFF20_B0B0, 32'hFFE8_E8E8
	};

	// Map a finished SGR code to the color it selects
	function automatic logic [31:0] sgr_lookup(
		input logic [6:0]  code,
		input logic [31:0] cur,
		input logic [31:0] dflt
	);
		logic [31:0] res;
		res = cur;
		if (code == '0) begin
			res = dflt;
		end else if (code >= FG_LO && code <= FG_HI) begin
			res = PALETTE[3'(code - FG_LO)];
		end else if (code >= FG_B_LO && code <= FG_B_HI) begin
			res = PALETTE[3'(code - FG_B_LO)];
		end
		return res;
	endfunction

endpackage

// ----- rtl/ansi_sgr_color_parser_top.sv -----
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_top: ANSI SGR color parser
// Results are registered; a result waits in the skid entry while the main one stalls.
// Throughput: one byte per cycle while the skid entry is empty; a two-entry output
//   register (main + skid) keeps the input open while one result waits to be taken.
// Reset: arst_n clears the parser mode, code state and both output entries,
//   and loads 0xFFFFFFFF as default and current color.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  sgr_pkg::sgr_in_t  char_beat,
	output logic            evt_valid,
	input  logic            evt_stall,
	output sgr_pkg::sgr_out_t evt_beat,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_data
);
	import sgr_pkg::*;

	sgr_mode_t   mode_q, mode_d;
	logic [6:0]  accum_q, accum_d;
	logic        seen_q, seen_d;
	logic [31:0] color_q, color_d;
	logic [31:0] default_q;

	sgr_out_t    res;
	sgr_out_t    out_q, skid_q;
	logic        out_vld_q, skid_vld_q;

	logic        accept, pop, is_digit, normal;
	logic [10:0] code_sum;
	logic [6:0]  finished_code;

	assign char_stall = skid_vld_q;
	assign accept     = char_valid & ~char_stall;
	assign evt_valid  = out_vld_q;
	assign evt_beat   = out_q;
	assign pop        = out_vld_q & ~evt_stall;

	// Decimal accumulate with saturation
	assign is_digit = (char_beat.text_byte >= CH_ZERO) && (char_beat.text_byte <= CH_NINE);
	assign code_sum = 11'(accum_q) * 11'd10 + 11'(8'(char_beat.text_byte - CH_ZERO));
	assign finished_code = accum_q;

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			accum_q   <= '0;
			seen_q    <= 1'b0;
			color_q   <= DEFAULT_RST;
			default_q <= DEFAULT_RST;
		end else if (cfg_we) begin
			default_q <= cfg_data;
			color_q   <= cfg_data;
		end else if (accept) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			seen_q  <= seen_d;
			color_q <= color_d;
		end
	end

	// Next state and result for the incoming byte
	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		seen_d  = seen_q;
		color_d = color_q;
		normal  = 1'b0;
		res     = '0;
		unique case (mode_q)
			MODE_CSI: begin
				if (is_digit) begin
					accum_d = (code_sum > 11'(CODE_MAX)) ? CODE_MAX : code_sum[6:0];
					seen_d  = 1'b1;
				end else begin
					// apply the pending code on ';' or on the closing byte
					if (seen_q) begin
						color_d = sgr_lookup(finished_code, color_q, default_q);
					end
					accum_d = '0;
					seen_d  = 1'b0;
					if (char_beat.text_byte != CH_SEMI) begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			MODE_ESC: begin
				if (char_beat.text_byte == CH_LBRACKET) begin
					mode_d  = MODE_CSI;
					accum_d = '0;
					seen_d  = 1'b0;
				end else begin
					mode_d = MODE_NORMAL;
					normal = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				normal = 1'b1;
			end
		endcase

		// Plain text handling
		if (normal) begin
			case (char_beat.text_byte)
				CH_ESC: mode_d = MODE_ESC;
				CH_LF:  res.event_kind = EV_NEWLINE;
				CH_CR:  res.event_kind = EV_CR;
				default: begin
					res.event_kind  = EV_GLYPH;
					res.glyph       = char_beat.text_byte;
					res.glyph_color = color_q;
				end
			endcase
		end
		res.end_flag = char_beat.string_end;

		// Return to string-start state after the last byte
		if (char_beat.string_end) begin
			mode_d  = MODE_NORMAL;
			accum_d = '0;
			seen_d  = 1'b0;
			color_d = default_q;
		end
	end

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Output payload, no reset
	always_ff @(posedge clk) begin
		if (pop || !out_vld_q) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

// ----- rtl/sgr_checker.sv -----
// ----------------------------------------------------------------------------
// sgr_checker: port-level checks for the ANSI SGR color parser
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module sgr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_stall,
	input logic              evt_valid,
	input logic              evt_stall,
	input sgr_pkg::sgr_out_t evt_beat
);
	import sgr_pkg::*;

	// Input stalls only while a result beat is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> evt_valid)
		else $error("input stalled with no result pending");

	// After every accepted byte, a result beat is valid on the next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall) |=> evt_valid)
		else $error("accepted byte produced no result");

	// Non-glyph events carry zero glyph and color
	a_nonglyph_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_beat.event_kind != EV_GLYPH) |->
			(evt_beat.glyph == '0 && evt_beat.glyph_color == '0))
		else $error("non-glyph event with payload");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_stall) |=> (evt_valid && $stable(evt_beat)))
		else $error("stalled result beat changed");

endmodule

bind ansi_sgr_color_parser_top sgr_checker u_sgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.evt_valid  (evt_valid),
	.evt_stall  (evt_stall),
	.evt_beat   (evt_beat)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the ANSI SGR color parser
// Feeds text bytes through the char channel and checks every event beat
// against an in-bench predictor of the parser (mode, SGR code collection,
// palette, string-end reset, default color register). Directed strings
// cover the byte extremes, palette codes, code saturation, empty codes,
// lone ESC and strings that end inside a sequence. Random text follows,
// with the default color rewritten between phases and, in most phases,
// random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import sgr_pkg::*;

	localparam logic [7:0] CH_SGR_END   = 8'h6D;   // 'm'
	localparam int         PHASE_CHARS  = 260;

	logic      clk;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	sgr_in_t   char_beat;
	logic      evt_valid;
	logic      evt_stall;
	sgr_out_t  evt_beat;
	logic      cfg_we;
	logic [31:0] cfg_data;

	// Parser model state
	sgr_mode_t   pm_mode;
	logic [6:0]  pm_code;
	logic        pm_seen;
	logic [31:0] pm_color;
	logic [31:0] pm_default;

	sgr_out_t expected_events[$];
	sgr_out_t got_evt;
	sgr_out_t want_evt;
	int       mismatch_count;
	int       chars_sent;
	bit       idle_on;

	ansi_sgr_color_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt_beat   (evt_beat),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#(8 * 400000);
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// Palette color chosen by a finished SGR code
	function automatic logic [31:0] sgr_code_color(input logic [6:0] code);
		logic [31:0] res;
		res = pm_color;
		if (code == 7'd0) begin
			res = pm_default;
		end else if (code >= 7'd30 && code <= 7'd37) begin
			res = PALETTE[3'(code - 7'd30)];
		end else if (code >= 7'd90 && code <= 7'd97) begin
			res = PALETTE[3'(code - 7'd90)];
		end
		return res;
	endfunction

	// Apply a pending code on ';' or on the byte that closes the sequence
	function automatic void close_code();
		if (pm_seen) begin
			pm_color = sgr_code_color(pm_code);
		end
		pm_code = '0;
		pm_seen = 1'b0;
	endfunction

	// Advance the parser model by one byte and return the event it yields
	function automatic sgr_out_t predict_event(input sgr_in_t b);
		sgr_out_t r;
		logic     plain;
		int       acc;
		r = '0;
		plain = 1'b0;
		case (pm_mode)
			MODE_CSI: begin
				if (b.text_byte >= CH_ZERO && b.text_byte <= CH_NINE) begin
					acc = int'(pm_code) * 10 + int'(b.text_byte - CH_ZERO);
					pm_code = (acc > int'(CODE_MAX)) ? CODE_MAX : 7'(acc);
					pm_seen = 1'b1;
				end else if (b.text_byte == CH_SEMI) begin
					close_code();
				end else begin
					close_code();
					pm_mode = MODE_NORMAL;
				end
			end
			MODE_ESC: begin
				if (b.text_byte == CH_LBRACKET) begin
					pm_mode = MODE_CSI;
					pm_code = '0;
					pm_seen = 1'b0;
				end else begin
					plain = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase
		if (plain) begin
			pm_mode = MODE_NORMAL;
			if (b.text_byte == CH_ESC) begin
				pm_mode = MODE_ESC;
			end else if (b.text_byte == CH_LF) begin
				r.event_kind = EV_NEWLINE;
			end else if (b.text_byte == CH_CR) begin
				r.event_kind = EV_CR;
			end else begin
				r.event_kind  = EV_GLYPH;
				r.glyph       = b.text_byte;
				r.glyph_color = pm_color;
			end
		end
		r.end_flag = b.string_end;
		// Return to string-start state after the last byte
		if (b.string_end) begin
			pm_mode  = MODE_NORMAL;
			pm_code  = '0;
			pm_seen  = 1'b0;
			pm_color = pm_default;
		end
		return r;
	endfunction

	// Send one byte beat, with an optional idle burst ahead of it
	task automatic send_char(input logic [7:0] ch, input logic last);
		sgr_in_t b;
		int      gap;
		b.text_byte  = ch;
		b.string_end = last;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= b;
		do @(posedge clk); while (char_stall);
		expected_events.push_back(predict_event(b));
		chars_sent++;
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], last && (i == s.len() - 1));
		end
	endtask

	// Hold the input and wait until every expected beat has come out
	task automatic drain();
		char_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_default_color(input logic [31:0] value);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		pm_default = value;
		pm_color   = value;
	endtask

	// Emit a decimal SGR code, sometimes empty or with a leading zero
	task automatic send_code_digits(input logic last_allowed);
		int kind;
		int code;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			return;
		end
		case (kind)
			1: code = 0;
			2, 3, 4: code = 30 + $urandom_range(0, 7);
			5, 6, 7: code = 90 + $urandom_range(0, 7);
			default: code = $urandom_range(0, 999);
		endcase
		if (kind == 9) begin
			send_char(CH_ZERO, last_allowed && $urandom_range(0, 59) == 0);
		end
		if (code >= 100) begin
			send_char(CH_ZERO + 8'((code / 100) % 10), last_allowed && $urandom_range(0, 59) == 0);
		end
		if (code >= 10) begin
			send_char(CH_ZERO + 8'((code / 10) % 10), last_allowed && $urandom_range(0, 59) == 0);
		end
		send_char(CH_ZERO + 8'(code % 10), last_allowed && $urandom_range(0, 59) == 0);
	endtask

	// One random chunk of text: mostly SGR sequences and glyphs, some noise
	task automatic send_random_chunk();
		int sel;
		int n;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			send_char(CH_ESC, $urandom_range(0, 59) == 0);
			send_char(CH_LBRACKET, $urandom_range(0, 59) == 0);
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				if (i > 0) begin
					send_char(CH_SEMI, $urandom_range(0, 59) == 0);
				end
				send_code_digits(1'b1);
			end
			if ($urandom_range(0, 9) < 7) begin
				send_char(CH_SGR_END, $urandom_range(0, 29) == 0);
			end else begin
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
			end
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				send_char(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 19) == 0);
			end
		end else if (sel < 85) begin
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
		end else if (sel < 92) begin
			send_char($urandom_range(0, 1) ? CH_LF : CH_CR, $urandom_range(0, 9) == 0);
		end else if (sel < 97) begin
			send_char(CH_ESC, $urandom_range(0, 19) == 0);
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
		end else begin
			// Noise made of sequence bytes in any order
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 3))
					0: send_char(CH_ESC, 1'b0);
					1: send_char(CH_LBRACKET, 1'b0);
					2: send_char(CH_SEMI, 1'b0);
					default: send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'($urandom_range(0, 1)));
				endcase
			end
		end
	endtask

	task automatic test_plain_bytes();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(CH_LF, 1'b0);
		send_char(CH_CR, 1'b0);
	endtask

	// Palette codes, a saturated code and a sequence closed by a non-'m' byte
	task automatic test_sgr_codes();
		send_char(CH_ESC, 1'b0);
		send_text("[97;500;31x", 1'b0);
		send_char(8'h41, 1'b1);
	endtask

	// ESC followed by ESC, then an empty code and code 0
	task automatic test_lone_escape();
		send_char(CH_ESC, 1'b0);
		send_char(CH_ESC, 1'b0);
		send_text("[;0mB", 1'b0);
	endtask

	task automatic test_end_inside_sequence();
		send_char(CH_ESC, 1'b0);
		send_text("[3", 1'b1);
		send_char(8'h43, 1'b0);
		send_char(CH_ESC, 1'b1);
		send_char(8'h44, 1'b0);
	endtask

	// Random text in phases, each starting with a new default color
	task automatic test_random_text();
		logic [31:0] colors [4];
		int          stop_at;
		colors[0] = 32'h0000_0000;
		colors[1] = 32'hFFFF_FFFF;
		colors[2] = $urandom;
		colors[3] = $urandom;
		foreach (colors[p]) begin
			write_default_color(colors[p]);
			idle_on = (p != 2) || ($urandom_range(0, 1) == 1);
			stop_at = chars_sent + PHASE_CHARS;
			while (chars_sent < stop_at) send_random_chunk();
		end
	endtask

	task automatic test_steady_stream();
		int stop_at;
		write_default_color($urandom);
		idle_on = 1'b0;
		stop_at = chars_sent + PHASE_CHARS;
		while (chars_sent < stop_at) send_random_chunk();
	endtask

	// Event side: random stall bursts
	initial begin
		evt_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				evt_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				evt_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted event beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall) begin
			got_evt = evt_beat;
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event beat %h", got_evt));
			end else begin
				want_evt = expected_events.pop_front();
				if (got_evt.event_kind != want_evt.event_kind) begin
					report_mismatch($sformatf("event_kind %0d, want %0d",
						got_evt.event_kind, want_evt.event_kind));
				end
				if (got_evt.glyph != want_evt.glyph) begin
					report_mismatch($sformatf("glyph %h, want %h",
						got_evt.glyph, want_evt.glyph));
				end
				if (got_evt.glyph_color != want_evt.glyph_color) begin
					report_mismatch($sformatf("glyph_color %h, want %h",
						got_evt.glyph_color, want_evt.glyph_color));
				end
				if (got_evt.end_flag != want_evt.end_flag) begin
					report_mismatch($sformatf("end_flag %b, want %b",
						got_evt.end_flag, want_evt.end_flag));
				end
			end
		end
	end

	initial begin
		int waited;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_beat  <= '0;
		cfg_we     <= 1'b0;
		cfg_data   <= '0;
		idle_on        = 1'b1;
		mismatch_count = 0;
		chars_sent     = 0;
		pm_mode    = MODE_NORMAL;
		pm_code    = '0;
		pm_seen    = 1'b0;
		pm_default = DEFAULT_RST;
		pm_color   = DEFAULT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_bytes();
		test_sgr_codes();
		test_lone_escape();
		test_end_inside_sequence();
		test_random_text();
		test_steady_stream();

		// Wait out the last beats, then report
		char_valid <= 1'b0;
		waited = 0;
		while (expected_events.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_events.size() != 0) begin
			report_mismatch($sformatf("%0d event beats never arrived", expected_events.size()));
		end
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
